@@ src/meam_pkg.sv @@
// Shared widths, limits, codes and control types of the masked error metrics accumulator.
package meam_pkg;

    localparam int SAMP_W = 24;
    localparam int THR_W  = 23;
    localparam int AD_W   = 24;
    localparam int SQT_W  = 36;
    localparam int SQ_W   = 64;
    localparam int ABS_W  = 45;
    localparam int RAT_W  = 44;
    localparam int TERM_W = 24;
    localparam int CNT_W  = 21;
    localparam int REM_W  = 30;
    localparam int DVD_W  = 52;
    localparam int QUO_W  = 40;
    localparam int ROOT_W = 26;
    localparam int DIV_W  = 24;
    localparam int STEP_W = 6;

    localparam int MSE_W  = 40;
    localparam int RMSE_W = 26;
    localparam int MAE_W  = 25;
    localparam int PCT_W  = 31;

    localparam int MAX_PAIRS = 1048576;
    localparam logic [CNT_W-1:0] PAIR_LIMIT =
        (MAX_PAIRS < (2 ** CNT_W) - 1) ? CNT_W'(MAX_PAIRS) : {CNT_W{1'b1}};

    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
    localparam logic [MSE_W-1:0]  MSE_MAX  = {MSE_W{1'b1}};
    localparam logic [MAE_W-1:0]  MAE_MAX  = {MAE_W{1'b1}};
    localparam logic [PCT_W-1:0]  PCT_MAX  = {PCT_W{1'b1}};

    localparam logic [1:0] CFG_MISS_REF  = 2'd0;
    localparam logic [1:0] CFG_MISS_PRED = 2'd1;
    localparam logic [1:0] CFG_RATIO_THR = 2'd2;

    typedef struct packed {
        logic clear;
        logic add_main;
        logic add_ratio;
        logic set_sat;
    } t_acc_ctl;

endpackage

@@ src/meam_step.sv @@
// Shared restoring step unit: one divide bit or one square root digit per use.
module meam_step import meam_pkg::*; (
    input  logic              i_sqrt,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [1:0]        i_bits,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [DIV_W-1:0]  i_dvsr,
    output logic [REM_W-1:0]  o_rem,
    output logic              o_bit
);

    logic [REM_W-1:0] w_pre;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    // Square root takes two dividend bits and tries 4*root+1; division takes one bit.
    assign w_pre   = i_sqrt ? {i_rem[REM_W-3:0], i_bits} : {i_rem[REM_W-2:0], i_bits[1]};
    assign w_trial = i_sqrt ? {2'b00, i_root, 2'b01}
                            : {{(REM_W - DIV_W){1'b0}}, i_dvsr};
    assign w_ge    = (w_pre >= w_trial);
    assign o_rem   = w_ge ? (w_pre - w_trial) : w_pre;
    assign o_bit   = w_ge;

endmodule

@@ src/meam_accum.sv @@
// Saturating accumulator bank: squared, absolute and ratio sums, pair count and flag.
module meam_accum import meam_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_ctl          i_ctl,
    input  logic [SQT_W-1:0]  i_sq_term,
    input  logic [AD_W-1:0]   i_abs_term,
    input  logic [TERM_W-1:0] i_ratio_term,
    output logic [SQ_W-1:0]   o_sq_sum,
    output logic [ABS_W-1:0]  o_abs_sum,
    output logic [RAT_W-1:0]  o_ratio_sum,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_sat
);

    logic [SQ_W-1:0]  r_sq;
    logic [ABS_W-1:0] r_abs;
    logic [RAT_W-1:0] r_rat;
    logic [CNT_W-1:0] r_cnt;
    logic             r_sat;

    logic [SQ_W:0]    w_sq_sum;
    logic [ABS_W:0]   w_abs_sum;
    logic [RAT_W:0]   w_rat_sum;

    assign w_sq_sum  = {1'b0, r_sq} + {{(SQ_W + 1 - SQT_W){1'b0}}, i_sq_term};
    assign w_abs_sum = {1'b0, r_abs} + {{(ABS_W + 1 - AD_W){1'b0}}, i_abs_term};
    assign w_rat_sum = {1'b0, r_rat} + {{(RAT_W + 1 - TERM_W){1'b0}}, i_ratio_term};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sq  <= '0;
            r_abs <= '0;
            r_rat <= '0;
            r_cnt <= '0;
            r_sat <= 1'b0;
        end else begin
            if (i_ctl.add_main) begin
                r_sq  <= w_sq_sum[SQ_W] ? {SQ_W{1'b1}} : w_sq_sum[SQ_W-1:0];
                r_abs <= w_abs_sum[ABS_W] ? {ABS_W{1'b1}} : w_abs_sum[ABS_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_ctl.add_ratio) begin
                r_rat <= w_rat_sum[RAT_W] ? {RAT_W{1'b1}} : w_rat_sum[RAT_W-1:0];
            end
            if (i_ctl.set_sat
                    || (i_ctl.add_main && (w_sq_sum[SQ_W] || w_abs_sum[ABS_W]))
                    || (i_ctl.add_ratio && w_rat_sum[RAT_W])) begin
                r_sat <= 1'b1;
            end
        end
    end

    assign o_sq_sum    = r_sq;
    assign o_abs_sum   = r_abs;
    assign o_ratio_sum = r_rat;
    assign o_count     = r_cnt;
    assign o_sat       = r_sat;

endmodule

@@ src/masked_error_metrics_accumulator_core.sv @@
// Top level of the masked error metrics accumulator: sequencer, shared step unit, result register.
//
//   channel | direction | handshake                     | payload
//   --------+-----------+-------------------------------+-----------------------------------
//   in      | to block  | i_in_valid / o_in_stall       | reference, predicted, last pair
//   out     | from block| o_out_valid / i_out_stall     | MSE, RMSE, MAE, percent, count, flag
//   cfg     | to block  | i_cfg_valid / o_cfg_ready     | register index and write data
//
// An item passes the multiply and accumulate states; one that adds a ratio term then takes
// the ratio quotient from the shared restoring step unit, one bit per cycle over 24 bits.
// An item marked last then runs the final divides (40, 25 and 31 quotient bits) and the
// 26-digit square root, all on the same step unit, and starts them only once the previous
// result has been taken from the output register.
// Reset clears the sequencer, the accumulators and the output valid and loads the register
// reset values. The block takes no item until the current one is finished; a stalled
// result holds in the output register while the block accepts and accumulates new items.
module masked_error_metrics_accumulator_core import meam_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [SAMP_W-1:0] i_reference_sample,
    input  logic signed [SAMP_W-1:0] i_predicted_sample,
    input  logic                     i_last_pair,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [MSE_W-1:0]         o_mean_squared_error,
    output logic [RMSE_W-1:0]        o_root_mean_squared_error,
    output logic [MAE_W-1:0]         o_mean_absolute_error,
    output logic [PCT_W-1:0]         o_percent_error,
    output logic [CNT_W-1:0]         o_valid_pairs,
    output logic                     o_overflow_seen,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [SAMP_W-1:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_RSTEP,
        S_RADD,
        S_FIN,
        S_MLOAD,
        S_MSTEP,
        S_QLOAD,
        S_QSTEP,
        S_ALOAD,
        S_ASTEP,
        S_PMUL,
        S_PLOAD,
        S_PSTEP,
        S_DONE
    } t_state;

    // Configuration registers.
    logic [SAMP_W-1:0] r_miss_ref;
    logic [SAMP_W-1:0] r_miss_pred;
    logic [THR_W-1:0]  r_thr;

    // Sequencer and datapath registers.
    t_state              r_state;
    logic [AD_W-1:0]     r_ad;
    logic [DIV_W-1:0]    r_ar;
    logic                r_take;
    logic                r_drop;
    logic                r_ren;
    logic                r_last;
    logic [SQT_W-1:0]    r_sqt;
    logic [TERM_W-1:0]   r_rterm;
    logic [REM_W-1:0]    r_rem;
    logic [DVD_W-1:0]    r_dvd;
    logic [QUO_W-1:0]    r_quo;
    logic [DIV_W-1:0]    r_dvsr;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_clp;

    // Result register.
    logic                r_ovalid;
    logic [MSE_W-1:0]    r_mse;
    logic [RMSE_W-1:0]   r_rmse;
    logic [MAE_W-1:0]    r_mae;
    logic [PCT_W-1:0]    r_pct;
    logic [CNT_W-1:0]    r_pairs;
    logic                r_ovf;

    // Front end: difference and magnitudes of the incoming pair.
    logic signed [SAMP_W:0] w_diff;
    logic [SAMP_W:0]        w_ad_full;
    logic [SAMP_W:0]        w_ar_full;
    logic                   w_present;
    logic                   w_room;
    logic [2*AD_W-1:0]      w_prod;

    // Accumulator bank.
    t_acc_ctl               w_ctl;
    logic [SQ_W-1:0]        w_sq_sum;
    logic [ABS_W-1:0]       w_abs_sum;
    logic [RAT_W-1:0]       w_ratio_sum;
    logic [CNT_W-1:0]       w_count;
    logic                   w_sat;

    // Shared step unit.
    logic                   w_sqrt;
    logic                   w_step;
    logic                   w_last_step;
    logic [REM_W-1:0]       w_rem_n;
    logic                   w_bit;
    logic [QUO_W-1:0]       w_quo_n;
    logic [DVD_W-2:0]       w_pct_ext;
    logic [DVD_W-2:0]       w_pct_prod;

    assign w_diff    = {i_reference_sample[SAMP_W-1], i_reference_sample}
                     - {i_predicted_sample[SAMP_W-1], i_predicted_sample};
    assign w_ad_full = w_diff[SAMP_W] ? ((SAMP_W + 1)'(0) - w_diff) : w_diff;
    assign w_ar_full = i_reference_sample[SAMP_W-1]
                     ? ((SAMP_W + 1)'(0) - {1'b1, i_reference_sample})
                     : {1'b0, i_reference_sample};
    assign w_present = (i_reference_sample != r_miss_ref)
                    && (i_predicted_sample != r_miss_pred);
    assign w_room    = (w_count < PAIR_LIMIT);
    assign w_prod    = r_ad * r_ad;

    // The final percentage needs ratio_sum * 100, built from three shifted copies.
    assign w_pct_ext  = {{(DVD_W - 1 - RAT_W){1'b0}}, w_ratio_sum};
    assign w_pct_prod = (w_pct_ext << 6) + (w_pct_ext << 5) + (w_pct_ext << 2);

    always_comb begin
        w_ctl           = '0;
        w_ctl.add_main  = (r_state == S_ACC) && r_take;
        w_ctl.set_sat   = (r_state == S_ACC) && r_drop;
        w_ctl.add_ratio = (r_state == S_RADD);
        w_ctl.clear     = (r_state == S_DONE);
    end

    meam_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_sq_term    (r_sqt),
        .i_abs_term   (r_ad),
        .i_ratio_term (r_rterm),
        .o_sq_sum     (w_sq_sum),
        .o_abs_sum    (w_abs_sum),
        .o_ratio_sum  (w_ratio_sum),
        .o_count      (w_count),
        .o_sat        (w_sat)
    );

    assign w_sqrt = (r_state == S_QSTEP);
    assign w_step = (r_state == S_RSTEP) || (r_state == S_MSTEP) || (r_state == S_QSTEP)
                 || (r_state == S_ASTEP) || (r_state == S_PSTEP);
    assign w_last_step = (r_cnt == STEP_W'(1));

    meam_step u_step (
        .i_sqrt (w_sqrt),
        .i_rem  (r_rem),
        .i_bits (r_dvd[DVD_W-1:DVD_W-2]),
        .i_root (r_quo[ROOT_W-1:0]),
        .i_dvsr (r_dvsr),
        .o_rem  (w_rem_n),
        .o_bit  (w_bit)
    );

    assign w_quo_n = {r_quo[QUO_W-2:0], w_bit};

    // Configuration registers take a write in any cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_ref  <= {1'b1, {(SAMP_W - 1){1'b0}}};
            r_miss_pred <= {1'b1, {(SAMP_W - 1){1'b0}}};
            r_thr       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MISS_REF:  r_miss_ref  <= i_cfg_data;
                CFG_MISS_PRED: r_miss_pred <= i_cfg_data;
                CFG_RATIO_THR: r_thr       <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            // Every step state advances the shared unit by one bit or one digit.
            if (w_step) begin
                r_rem <= w_rem_n;
                r_quo <= w_quo_n;
                r_dvd <= w_sqrt ? {r_dvd[DVD_W-3:0], 2'b00} : {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - STEP_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ad    <= w_ad_full[AD_W-1:0];
                        r_ar    <= w_ar_full[DIV_W-1:0];
                        r_take  <= w_present && w_room;
                        r_drop  <= w_present && !w_room;
                        r_ren   <= w_present && w_room
                                && (w_ar_full[DIV_W-1:0] > {1'b0, r_thr});
                        r_last  <= i_last_pair;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Squared term, and the ratio divide set up as (|d| << 16) / |r|.
                    r_sqt   <= w_prod[2*AD_W-1:12];
                    r_rem   <= {{(REM_W - AD_W + 8){1'b0}}, r_ad[AD_W-1:8]};
                    r_dvd   <= {r_ad[7:0], {(DVD_W - 8){1'b0}}};
                    r_dvsr  <= r_ar;
                    r_clp   <= ({8'b0, r_ad[AD_W-1:8]} >= r_ar);
                    r_quo   <= '0;
                    r_cnt   <= STEP_W'(TERM_W);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_ren) begin
                        r_state <= S_RSTEP;
                    end else if (r_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RSTEP: begin
                    if (w_last_step) begin
                        r_rterm <= r_clp ? TERM_MAX : w_quo_n[TERM_W-1:0];
                        r_state <= S_RADD;
                    end
                end
                S_RADD: begin
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    // The result fields are written in place, so wait for the last
                    // result to leave the output register.
                    if (!r_ovalid) begin
                        if (w_count == '0) begin
                            r_mse   <= '0;
                            r_rmse  <= '0;
                            r_mae   <= '0;
                            r_pct   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MLOAD;
                        end
                    end
                end
                S_MLOAD: begin
                    r_rem   <= {{(REM_W - (SQ_W - MSE_W)){1'b0}}, w_sq_sum[SQ_W-1:MSE_W]};
                    r_dvd   <= {w_sq_sum[MSE_W-1:0], {(DVD_W - MSE_W){1'b0}}};
                    r_dvsr  <= {{(DIV_W - CNT_W){1'b0}}, w_count};
                    r_clp   <= (w_sq_sum[SQ_W-1:MSE_W] >= {{(DIV_W - CNT_W){1'b0}}, w_count});
                    r_quo   <= '0;
                    r_cnt   <= STEP_W'(MSE_W);
                    r_state <= S_MSTEP;
                end
                S_MSTEP: begin
                    if (w_last_step) begin
                        r_mse   <= r_clp ? MSE_MAX : w_quo_n[MSE_W-1:0];
                        r_state <= S_QLOAD;
                    end
                end
                S_QLOAD: begin
                    // Root of mse << 12 taken two bits at a time from the top.
                    r_rem   <= '0;
                    r_dvd   <= {r_mse, {(DVD_W - MSE_W){1'b0}}};
                    r_quo   <= '0;
                    r_cnt   <= STEP_W'(RMSE_W);
                    r_state <= S_QSTEP;
                end
                S_QSTEP: begin
                    if (w_last_step) begin
                        r_rmse  <= w_quo_n[RMSE_W-1:0];
                        r_state <= S_ALOAD;
                    end
                end
                S_ALOAD: begin
                    r_rem   <= {{(REM_W - (ABS_W - MAE_W)){1'b0}}, w_abs_sum[ABS_W-1:MAE_W]};
                    r_dvd   <= {w_abs_sum[MAE_W-1:0], {(DVD_W - MAE_W){1'b0}}};
                    r_clp   <= ({1'b0, w_abs_sum[ABS_W-1:MAE_W]} >= w_count);
                    r_quo   <= '0;
                    r_cnt   <= STEP_W'(MAE_W);
                    r_state <= S_ASTEP;
                end
                S_ASTEP: begin
                    if (w_last_step) begin
                        r_mae   <= r_clp ? MAE_MAX : w_quo_n[MAE_W-1:0];
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    r_dvd   <= {1'b0, w_pct_prod};
                    r_state <= S_PLOAD;
                end
                S_PLOAD: begin
                    r_rem   <= {{(REM_W - (DVD_W - 1 - PCT_W)){1'b0}}, r_dvd[DVD_W-2:PCT_W]};
                    r_clp   <= ({1'b0, r_dvd[DVD_W-2:PCT_W]} >= w_count);
                    r_dvd   <= {r_dvd[PCT_W-1:0], {(DVD_W - PCT_W){1'b0}}};
                    r_quo   <= '0;
                    r_cnt   <= STEP_W'(PCT_W);
                    r_state <= S_PSTEP;
                end
                S_PSTEP: begin
                    if (w_last_step) begin
                        r_pct   <= r_clp ? PCT_MAX : w_quo_n[PCT_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // An empty data set reports a clear flag as well.
                    r_pairs  <= w_count;
                    r_ovf    <= w_sat && (w_count != '0);
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall                = (r_state != S_IDLE);
    assign o_cfg_ready               = 1'b1;
    assign o_out_valid               = r_ovalid;
    assign o_mean_squared_error      = r_mse;
    assign o_root_mean_squared_error = r_rmse;
    assign o_mean_absolute_error     = r_mae;
    assign o_percent_error           = r_pct;
    assign o_valid_pairs             = r_pairs;
    assign o_overflow_seen           = r_ovf;

    // A new result is only produced from the finishing state.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result valid raised outside the finishing state");

    // The finishing state never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_ovalid)
        else $error("result register overwritten while still valid");

    // The accumulators are empty after a result is formed.
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (w_count == '0) && !w_sat)
        else $error("accumulators not cleared after a result");

    // Step states always have a bit left to produce.
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (r_cnt != '0))
        else $error("step unit used with an exhausted step count");

    // The pair count never passes its limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (w_count <= PAIR_LIMIT))
        else $error("pair count beyond its limit");

endmodule
